// ===== rtl/core/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg: shared types and codes of the positional list engine
// Command and status codes, item field widths and the control bundle that
// the list controller broadcasts along the row of cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

   // item field widths
   localparam int CMD_W   = 2;
   localparam int POS_W   = 5;
   localparam int DATA_W  = 32;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 5;

   // command codes
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd3;

   // status codes
   localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

   // operation seen by every cell in one cycle
   typedef enum logic [2:0] {
      CELL_IDLE,
      CELL_READ,
      CELL_WRITE,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

   // broadcast bundle from the controller to the cells
   typedef struct packed {
      cell_op_type             op;
      logic [DATA_W-1:0]       value;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell: one entry of the list
// Holds one value and, on insert or remove, takes the value of its left or
// right neighbour so that the whole row shifts together in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_cell #(
   parameter int SEL_W = 6,
   parameter int INDEX = 0
) (
   input  wire logic                            clock,
   input  wire ple_pkg::cell_ctl_type           ctl,
   input  wire logic [SEL_W-1:0]                sel,
   input  wire logic [ple_pkg::DATA_W-1:0]      left_value,
   input  wire logic [ple_pkg::DATA_W-1:0]      right_value,
   output logic      [ple_pkg::DATA_W-1:0]      data_out,
   output logic      [ple_pkg::DATA_W-1:0]      rd_data
);

   localparam logic [SEL_W-1:0] MY_INDEX = SEL_W'(INDEX);

   logic [ple_pkg::DATA_W-1:0] data_ff;
   logic [ple_pkg::DATA_W-1:0] data_in;
   logic                       hit;
   logic                       after;

   // where this cell sits relative to the addressed entry
   assign hit   = (MY_INDEX == sel);
   assign after = (MY_INDEX > sel);

   // next value of the entry
   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         ple_pkg::CELL_WRITE: begin
            if (hit) data_in = ctl.value;
         end
         ple_pkg::CELL_INSERT: begin
            if (hit) data_in = ctl.value;
            else if (after) data_in = left_value;
         end
         ple_pkg::CELL_REMOVE: begin
            if (hit || after) data_in = right_value;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   // entry storage, no reset needed
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // masked read so the controller can or the row together
   assign rd_data  = (ctl.op == ple_pkg::CELL_READ && hit) ? data_ff : '0;
   assign data_out = data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/positional_list_engine.sv =====
// A result appears, registered, in the cycle after its item is accepted.
// One item per cycle unless a held result is stalled; every cell of the row
// updates in the same cycle, and the result register frees once taken.
// Reset clears the entry count and the result valid flag; the entries
// themselves are not cleared and are only ever read after being written.
// ----------------------------------------------------------------------------
// positional_list_engine: ordered list with insert and remove by position
// A controller checks the position against the entry count and broadcasts
// one operation to a row of cells that read, overwrite or shift in place.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine #(
   parameter int CAPACITY = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic        [ple_pkg::CMD_W-1:0]      req_command,
   input  wire logic        [ple_pkg::POS_W-1:0]      req_position,
   input  wire logic signed [ple_pkg::DATA_W-1:0]     req_value,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed      [ple_pkg::DATA_W-1:0]     rsp_read_value,
   output logic             [ple_pkg::STAT_W-1:0]     rsp_status,
   output logic             [ple_pkg::COUNT_W-1:0]    rsp_count,
   output logic                                       rsp_empty_res
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SEL_W = ((CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W) + 1;
   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

   logic [CNT_W-1:0]                count_ff;
   logic [CNT_W-1:0]                count_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [ple_pkg::DATA_W-1:0]      rd_ff;
   logic [ple_pkg::DATA_W-1:0]      rd_in;
   logic [ple_pkg::STAT_W-1:0]      status_ff;
   logic [ple_pkg::STAT_W-1:0]      status_in;

   logic                            accept;
   logic [SEL_W-1:0]                pos_ext;
   logic [SEL_W-1:0]                cnt_ext;
   logic [SEL_W-1:0]                sel;
   logic                            bad_pos;
   logic                            full;
   ple_pkg::cell_ctl_type           ctl;
   logic [ple_pkg::DATA_W-1:0]      cell_q  [CAPACITY];
   logic [ple_pkg::DATA_W-1:0]      cell_rd [CAPACITY];
   logic [ple_pkg::DATA_W-1:0]      row_rd;

   // take a new item whenever the result register is free or draining
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // position checks against the current count
   assign pos_ext = SEL_W'(req_position);
   assign cnt_ext = SEL_W'(count_ff);
   assign sel     = pos_ext - SEL_W'(1);
   assign full    = (count_ff == CAP_COUNT);

   always_comb begin
      if (req_command == ple_pkg::CMD_INSERT) begin
         bad_pos = (pos_ext == '0) || (pos_ext > cnt_ext + SEL_W'(1));
      end else begin
         bad_pos = (pos_ext == '0) || (pos_ext > cnt_ext);
      end
   end

   // command decode: cell operation, count, status and read data
   always_comb begin
      ctl.op    = ple_pkg::CELL_IDLE;
      ctl.value = req_value;
      count_in  = count_ff;
      status_in = ple_pkg::ST_DONE;
      rd_in     = '0;
      if (accept) begin
         if (bad_pos) begin
            status_in = ple_pkg::ST_INVALID;
            if (req_command == ple_pkg::CMD_READ) rd_in = '1;
         end else begin
            case (req_command)
               ple_pkg::CMD_READ: begin
                  ctl.op = ple_pkg::CELL_READ;
                  rd_in  = row_rd;
               end
               ple_pkg::CMD_WRITE: begin
                  ctl.op = ple_pkg::CELL_WRITE;
               end
               ple_pkg::CMD_INSERT: begin
                  if (full) begin
                     status_in = ple_pkg::ST_FULL;
                  end else begin
                     ctl.op   = ple_pkg::CELL_INSERT;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               ple_pkg::CMD_REMOVE: begin
                  ctl.op   = ple_pkg::CELL_REMOVE;
                  count_in = count_ff - CNT_W'(1);
               end
               default: begin
                  ctl.op = ple_pkg::CELL_IDLE;
               end
            endcase
         end
      end
   end

   // result register hand-off
   always_comb begin
      if (accept) rsp_valid_in = 1'b1;
      else if (rsp_stall) rsp_valid_in = rsp_valid_ff;
      else rsp_valid_in = 1'b0;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded with each accepted item
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff     <= rd_in;
         status_ff <= status_in;
      end
   end

   // row of cells, each linked to its neighbours
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ple_pkg::DATA_W-1:0] left_v;
      logic [ple_pkg::DATA_W-1:0] right_v;

      if (i == 0) begin : g_first
         assign left_v = cell_q[i];
      end else begin : g_mid_l
         assign left_v = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_v = cell_q[i];
      end else begin : g_mid_r
         assign right_v = cell_q[i+1];
      end

      ple_cell #(
         .SEL_W (SEL_W),
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .sel         (sel),
         .left_value  (left_v),
         .right_value (right_v),
         .data_out    (cell_q[i]),
         .rd_data     (cell_rd[i])
      );
   end

   // or together the masked read data of the row
   always_comb begin
      row_rd = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         row_rd = row_rd | cell_rd[k];
      end
   end

   // outputs
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rd_ff;
   assign rsp_status     = status_ff;
   assign rsp_count      = ple_pkg::COUNT_W'(count_ff);
   assign rsp_empty_res  = (count_ff == '0);

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_COUNT)
      else $error("entry count above capacity");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted item gave no result");

   a_bad_pos_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (accept && bad_pos) |=> $stable(count_ff))
      else $error("rejected item changed the count");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && !bad_pos && req_command == ple_pkg::CMD_INSERT && !full)
      |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the list by one");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (accept && status_in == ple_pkg::ST_FULL) |-> (count_ff == CAP_COUNT))
      else $error("full status on a list with room");

endmodule

`default_nettype wire
